// ===== design/lrs_pkg.sv =====
package lrs_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned OpW    = 3;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned IntvW  = 31;
  localparam int unsigned CountW = 8;
  localparam int unsigned CodeW  = 3;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  // Register reset values.
  localparam logic [IntvW-1:0]  BaseIntvReset  = 31'd1000;
  localparam logic [IntvW-1:0]  MaxIntvReset   = 31'd30000;
  localparam logic [TimeW-1:0]  ConnToReset    = 32'd10000;
  localparam logic [TimeW-1:0]  HbToReset      = 32'd60000;
  localparam logic [CountW-1:0] MaxAttReset    = 8'd10;

  typedef enum logic [2:0] {
    ST_DISC    = 3'd0,
    ST_ADV     = 3'd1,
    ST_CONNING = 3'd2,
    ST_CONN    = 3'd3,
    ST_RECON   = 3'd4,
    ST_ERR     = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_CONNECTED = 3'd1,
    EV_LOST      = 3'd2,
    EV_RECON     = 3'd3,
    EV_FAILED    = 3'd4
  } event_t;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_CONNECTED  = 3'd1,
    OP_CONNECTING = 3'd2,
    OP_DISCONNECT = 3'd3,
    OP_RECONNECT  = 3'd4,
    OP_HEARTBEAT  = 3'd5,
    OP_BEGIN      = 3'd6
  } opcode_t;

  typedef enum logic [2:0] {
    REG_BASE_INTV = 3'd0,
    REG_MAX_INTV  = 3'd1,
    REG_CONN_TO   = 3'd2,
    REG_HB_TO     = 3'd3,
    REG_MAX_ATT   = 3'd4
  } reg_idx_t;

  // Configuration register set.
  typedef struct packed {
    logic [IntvW-1:0]  base_intv;
    logic [IntvW-1:0]  max_intv;
    logic [TimeW-1:0]  conn_to;
    logic [TimeW-1:0]  hb_to;
    logic [CountW-1:0] max_att;
  } cfg_t;

  // Supervisor state carried from one request to the next.
  typedef struct packed {
    phase_t            phase;
    logic [TimeW-1:0]  last_attempt;
    logic [TimeW-1:0]  last_hb;
    logic [IntvW-1:0]  intv;
    logic [CountW-1:0] attempts;
  } link_st_t;

endpackage

// ===== design/lrs_cfg_regs.sv =====
module lrs_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lrs_pkg::AddrW-1:0]   paddr,
  input  logic [lrs_pkg::DataW-1:0]   pwdata,
  output logic [lrs_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output lrs_pkg::cfg_t               cfg
);

  lrs_pkg::cfg_t    cfg_r;
  lrs_pkg::cfg_t    cfg_nxt;
  lrs_pkg::reg_idx_t idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = lrs_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  // Register write decode; unmapped addresses are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        lrs_pkg::REG_BASE_INTV: cfg_nxt.base_intv = pwdata[lrs_pkg::IntvW-1:0];
        lrs_pkg::REG_MAX_INTV:  cfg_nxt.max_intv  = pwdata[lrs_pkg::IntvW-1:0];
        lrs_pkg::REG_CONN_TO:   cfg_nxt.conn_to   = pwdata;
        lrs_pkg::REG_HB_TO:     cfg_nxt.hb_to     = pwdata;
        lrs_pkg::REG_MAX_ATT:   cfg_nxt.max_att   = pwdata[lrs_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_intv <= lrs_pkg::BaseIntvReset;
      cfg_r.max_intv  <= lrs_pkg::MaxIntvReset;
      cfg_r.conn_to   <= lrs_pkg::ConnToReset;
      cfg_r.hb_to     <= lrs_pkg::HbToReset;
      cfg_r.max_att   <= lrs_pkg::MaxAttReset;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (idx)
      lrs_pkg::REG_BASE_INTV: prdata = {1'b0, cfg_r.base_intv};
      lrs_pkg::REG_MAX_INTV:  prdata = {1'b0, cfg_r.max_intv};
      lrs_pkg::REG_CONN_TO:   prdata = cfg_r.conn_to;
      lrs_pkg::REG_HB_TO:     prdata = cfg_r.hb_to;
      lrs_pkg::REG_MAX_ATT:   prdata = {24'd0, cfg_r.max_att};
      default:                prdata = '0;
    endcase
  end

endmodule

// ===== design/lrs_next.sv =====
module lrs_next (
  input  lrs_pkg::cfg_t                cfg,
  input  lrs_pkg::link_st_t            st,
  input  logic [lrs_pkg::OpW-1:0]      opcode,
  input  logic [lrs_pkg::TimeW-1:0]    now_ms,
  output lrs_pkg::link_st_t            st_nxt,
  output lrs_pkg::event_t              ev,
  output logic [lrs_pkg::TimeW-1:0]    connected_for
);

  lrs_pkg::phase_t            req_phase;
  logic                       req_en;
  logic                       force_fail;
  logic [lrs_pkg::TimeW-1:0]  since_attempt;
  logic [lrs_pkg::TimeW-1:0]  since_hb;
  logic [lrs_pkg::TimeW-1:0]  dbl_intv;
  logic                       intv_elapsed;

  assign since_attempt = now_ms - st.last_attempt;
  assign since_hb      = now_ms - st.last_hb;
  assign dbl_intv      = {st.intv, 1'b0};
  assign intv_elapsed  = since_attempt > {1'b0, st.intv};

  always_comb begin
    st_nxt     = st;
    ev         = lrs_pkg::EV_NONE;
    req_en     = 1'b0;
    req_phase  = st.phase;
    force_fail = 1'b0;

    // Opcode decode: updates that precede any state request.
    unique case (lrs_pkg::opcode_t'(opcode))
      lrs_pkg::OP_TICK: begin
        unique case (st.phase) inside
          lrs_pkg::ST_DISC: begin
            if (intv_elapsed) begin
              req_en    = 1'b1;
              req_phase = lrs_pkg::ST_RECON;
            end
          end
          lrs_pkg::ST_ADV, lrs_pkg::ST_CONNING: begin
            if (since_attempt > cfg.conn_to) begin
              req_en    = 1'b1;
              req_phase = lrs_pkg::ST_RECON;
            end
          end
          lrs_pkg::ST_CONN: begin
            if (since_hb > cfg.hb_to) begin
              req_en    = 1'b1;
              req_phase = lrs_pkg::ST_DISC;
            end
          end
          lrs_pkg::ST_RECON: begin
            if (intv_elapsed) begin
              req_en = 1'b1;
              if (st.attempts < cfg.max_att) begin
                // Count the attempt and double the interval up to the ceiling.
                st_nxt.attempts     = st.attempts + 8'd1;
                st_nxt.intv         = (dbl_intv < {1'b0, cfg.max_intv}) ?
                                      dbl_intv[lrs_pkg::IntvW-1:0] : cfg.max_intv;
                st_nxt.last_attempt = now_ms;
                req_phase           = lrs_pkg::ST_ADV;
              end else begin
                req_phase  = lrs_pkg::ST_ERR;
                force_fail = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      lrs_pkg::OP_CONNECTED: begin
        req_en    = 1'b1;
        req_phase = lrs_pkg::ST_CONN;
      end
      lrs_pkg::OP_CONNECTING: begin
        req_en    = 1'b1;
        req_phase = lrs_pkg::ST_CONNING;
      end
      lrs_pkg::OP_DISCONNECT: begin
        req_en    = 1'b1;
        req_phase = lrs_pkg::ST_DISC;
      end
      lrs_pkg::OP_RECONNECT: begin
        st_nxt.attempts = '0;
        st_nxt.intv     = cfg.base_intv;
        req_en          = 1'b1;
        req_phase       = lrs_pkg::ST_RECON;
      end
      lrs_pkg::OP_HEARTBEAT: begin
        st_nxt.last_hb = now_ms;
      end
      lrs_pkg::OP_BEGIN: begin
        st_nxt.phase    = lrs_pkg::ST_DISC;
        st_nxt.attempts = '0;
        st_nxt.intv     = cfg.base_intv;
      end
      default: ;
    endcase

    // State entry: a request for the state already held does nothing.
    if (req_en && (req_phase != st.phase)) begin
      st_nxt.phase = req_phase;
      unique case (req_phase)
        lrs_pkg::ST_CONN: begin
          st_nxt.intv     = cfg.base_intv;
          st_nxt.attempts = '0;
          st_nxt.last_hb  = now_ms;
          ev              = lrs_pkg::EV_CONNECTED;
        end
        lrs_pkg::ST_DISC: begin
          ev = (st.phase == lrs_pkg::ST_CONN) ? lrs_pkg::EV_LOST : lrs_pkg::EV_NONE;
        end
        lrs_pkg::ST_RECON: ev = lrs_pkg::EV_RECON;
        default:           ev = lrs_pkg::EV_NONE;
      endcase
    end

    // Giving up reports a failure regardless of the entry event.
    if (force_fail) begin
      ev = lrs_pkg::EV_FAILED;
    end
  end

  assign connected_for = (st_nxt.phase == lrs_pkg::ST_CONN) ?
                         (now_ms - st_nxt.last_attempt) : '0;

endmodule

// ===== design/link_reconnect_supervisor_top.sv =====
// Each result passes two registers: the accepting edge loads the input register, and the
// result register loads when the request advances, which a stalled result side can hold off.
// Throughput: one request per cycle; the supervisor state updates in a single
// pass through the next-state logic, so requests stall only while the result side holds off.
// Reset (rst_n low, synchronous): both pipeline stages empty, link disconnected,
// times and attempts zero, interval and registers at their default values.
module link_reconnect_supervisor_top (
  input  logic                        clk,
  input  logic                        rst_n,
  // Request channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lrs_pkg::OpW-1:0]     in_opcode,
  input  logic [lrs_pkg::TimeW-1:0]   in_now_ms,
  // Result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_link_state,
  output logic [lrs_pkg::CodeW-1:0]   out_event_code,
  output logic [lrs_pkg::CountW-1:0]  out_attempt_count,
  output logic [lrs_pkg::IntvW-1:0]   out_current_interval,
  output logic [lrs_pkg::TimeW-1:0]   out_connected_for,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lrs_pkg::AddrW-1:0]   paddr,
  input  logic [lrs_pkg::DataW-1:0]   pwdata,
  output logic [lrs_pkg::DataW-1:0]   prdata,
  output logic                        pready
);

  lrs_pkg::cfg_t               cfg;
  lrs_pkg::link_st_t           st_r;
  lrs_pkg::link_st_t           st_nxt;
  lrs_pkg::event_t             ev_nxt;
  logic [lrs_pkg::TimeW-1:0]   conn_for_nxt;

  logic                        s1_valid_r;
  logic [lrs_pkg::OpW-1:0]     s1_opcode_r;
  logic [lrs_pkg::TimeW-1:0]   s1_now_r;

  logic                        out_valid_r;
  logic [2:0]                  out_state_r;
  logic [lrs_pkg::CodeW-1:0]   out_event_r;
  logic [lrs_pkg::CountW-1:0]  out_att_r;
  logic [lrs_pkg::IntvW-1:0]   out_intv_r;
  logic [lrs_pkg::TimeW-1:0]   out_conn_for_r;

  logic                        out_free;
  logic                        advance;
  logic                        in_fire;

  lrs_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lrs_next u_next (
    .cfg           (cfg),
    .st            (st_r),
    .opcode        (s1_opcode_r),
    .now_ms        (s1_now_r),
    .st_nxt        (st_nxt),
    .ev            (ev_nxt),
    .connected_for (conn_for_nxt)
  );

  // Pipeline flow control: the result register frees up when empty or taken.
  assign out_free = !out_valid_r || out_ready;
  assign advance  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_fire  = in_valid && in_ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_opcode_r <= in_opcode;
      s1_now_r    <= in_now_ms;
    end
  end

  // Supervisor state commits as each request moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase        <= lrs_pkg::ST_DISC;
      st_r.last_attempt <= '0;
      st_r.last_hb      <= '0;
      st_r.intv         <= lrs_pkg::BaseIntvReset;
      st_r.attempts     <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_state_r    <= st_nxt.phase;
      out_event_r    <= ev_nxt;
      out_att_r      <= st_nxt.attempts;
      out_intv_r     <= st_nxt.intv;
      out_conn_for_r <= conn_for_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_link_state       = out_state_r;
  assign out_event_code       = out_event_r;
  assign out_attempt_count    = out_att_r;
  assign out_current_interval = out_intv_r;
  assign out_connected_for    = out_conn_for_r;

  // A request leaving the input register always lands in the result register.
  assert property (@(posedge clk) disable iff (!rst_n) advance |=> out_valid_r)
    else $error("result register did not capture an advancing request");

  // A connected event leaves the link connected with attempts cleared.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_event_r == lrs_pkg::EV_CONNECTED) |->
      (out_state_r == lrs_pkg::ST_CONN && out_att_r == '0))
    else $error("connected event without connected state");

  // Connection time is reported only while connected.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_state_r != lrs_pkg::ST_CONN) |-> (out_conn_for_r == '0))
    else $error("nonzero connection time outside connected state");

  // Failure always lands in the error state; a loss always lands disconnected.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_event_r == lrs_pkg::EV_FAILED) |-> (out_state_r == lrs_pkg::ST_ERR))
    else $error("failure event outside error state");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_event_r == lrs_pkg::EV_LOST) |-> (out_state_r == lrs_pkg::ST_DISC))
    else $error("lost event outside disconnected state");

endmodule

// ===== dv/link_reconnect_supervisor_checker.sv =====
module link_reconnect_supervisor_checker
  import lrs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [OpW-1:0]      in_opcode,
  input  logic [TimeW-1:0]    in_now_ms,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [2:0]          out_link_state,
  input  logic [CodeW-1:0]    out_event_code,
  input  logic [CountW-1:0]   out_attempt_count,
  input  logic [IntvW-1:0]    out_current_interval,
  input  logic [TimeW-1:0]    out_connected_for,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [AddrW-1:0]    paddr,
  input  logic [DataW-1:0]    pwdata,
  output int unsigned         pending_results,
  output int unsigned         mismatch_count
);

  // One predicted result of the supervisor.
  typedef struct packed {
    phase_t            state;
    event_t            code;
    logic [CountW-1:0] attempts;
    logic [IntvW-1:0]  intv;
    logic [TimeW-1:0]  conn_for;
  } link_status_t;

  cfg_t         regs;
  link_st_t     sup;
  link_status_t predicted_status_q[$];
  link_status_t want;
  int unsigned  results_seen;

  // Move to a new state and return the event the move reports.
  function automatic event_t move_to(phase_t target, logic [TimeW-1:0] now);
    phase_t prior;
    prior = sup.phase;
    if (prior == target) return EV_NONE;
    sup.phase = target;
    case (target)
      ST_CONN: begin
        sup.intv     = regs.base_intv;
        sup.attempts = '0;
        sup.last_hb  = now;
        return EV_CONNECTED;
      end
      ST_DISC: begin
        if (prior == ST_CONN) return EV_LOST;
        return EV_NONE;
      end
      ST_RECON: return EV_RECON;
      default: return EV_NONE;
    endcase
  endfunction

  // Timeout rules; every elapsed time is a wrapping 32-bit difference.
  function automatic event_t apply_tick(logic [TimeW-1:0] now);
    logic [TimeW-1:0] since;
    logic [TimeW-1:0] quiet;
    logic [TimeW-1:0] doubled;
    event_t           ev;
    since = now - sup.last_attempt;
    quiet = now - sup.last_hb;
    ev    = EV_NONE;
    case (sup.phase) inside
      ST_DISC: begin
        if (since > {1'b0, sup.intv}) ev = move_to(ST_RECON, now);
      end
      ST_ADV, ST_CONNING: begin
        if (since > regs.conn_to) ev = move_to(ST_RECON, now);
      end
      ST_CONN: begin
        if (quiet > regs.hb_to) ev = move_to(ST_DISC, now);
      end
      ST_RECON: begin
        if (since > {1'b0, sup.intv}) begin
          if (sup.attempts < regs.max_att) begin
            doubled          = {sup.intv, 1'b0};
            sup.attempts     = sup.attempts + 1'b1;
            sup.intv         = (doubled < {1'b0, regs.max_intv}) ? doubled[IntvW-1:0]
                                                                 : regs.max_intv;
            sup.last_attempt = now;
            ev               = move_to(ST_ADV, now);
          end else begin
            void'(move_to(ST_ERR, now));
            ev = EV_FAILED;
          end
        end
      end
      default: ev = EV_NONE;
    endcase
    return ev;
  endfunction

  // Apply one request to the supervisor copy and form its result.
  function automatic link_status_t supervise(logic [OpW-1:0] op_bits, logic [TimeW-1:0] now);
    link_status_t res;
    event_t       ev;
    ev = EV_NONE;
    case (op_bits)
      OP_TICK:       ev = apply_tick(now);
      OP_CONNECTED:  ev = move_to(ST_CONN, now);
      OP_CONNECTING: ev = move_to(ST_CONNING, now);
      OP_DISCONNECT: ev = move_to(ST_DISC, now);
      OP_RECONNECT: begin
        sup.attempts = '0;
        sup.intv     = regs.base_intv;
        ev           = move_to(ST_RECON, now);
      end
      OP_HEARTBEAT: sup.last_hb = now;
      OP_BEGIN: begin
        sup.phase    = ST_DISC;
        sup.attempts = '0;
        sup.intv     = regs.base_intv;
      end
      default: ev = EV_NONE;
    endcase
    res.state    = sup.phase;
    res.code     = ev;
    res.attempts = sup.attempts;
    res.intv     = sup.intv;
    res.conn_for = (sup.phase == ST_CONN) ? now - sup.last_attempt : '0;
    return res;
  endfunction

  // Print one line per mismatch and count every one.
  task automatic report_mismatch(input string what, input logic [31:0] seen,
                                 input logic [31:0] wanted);
    mismatch_count++;
    $display("ERROR at %0t: result %0d %s: got 0x%0h, expected 0x%0h",
             $time, results_seen, what, seen, wanted);
  endtask

  // Watch the request, result and register channels at every rising edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      regs = '{base_intv: BaseIntvReset, max_intv: MaxIntvReset, conn_to: ConnToReset,
               hb_to: HbToReset, max_att: MaxAttReset};
      sup  = '{phase: ST_DISC, last_attempt: '0, last_hb: '0, intv: BaseIntvReset,
               attempts: '0};
      predicted_status_q.delete();
      mismatch_count = 0;
      results_seen   = 0;
    end else begin
      // Compare a delivered result with the oldest prediction.
      if (out_valid && out_ready) begin
        if (predicted_status_q.size() == 0) begin
          report_mismatch("arrived with no request outstanding", out_link_state, '0);
        end else begin
          want = predicted_status_q.pop_front();
          if (out_link_state !== want.state)
            report_mismatch("link_state", out_link_state, want.state);
          if (out_event_code !== want.code)
            report_mismatch("event_code", out_event_code, want.code);
          if (out_attempt_count !== want.attempts)
            report_mismatch("attempt_count", out_attempt_count, want.attempts);
          if (out_current_interval !== want.intv)
            report_mismatch("current_interval", out_current_interval, want.intv);
          if (out_connected_for !== want.conn_for)
            report_mismatch("connected_for", out_connected_for, want.conn_for);
        end
        results_seen++;
      end

      // Predict the result of each accepted request.
      if (in_valid && in_ready) predicted_status_q.push_back(supervise(in_opcode, in_now_ms));

      // Track register writes; addresses past the last register are ignored.
      if (psel && penable && pwrite && pready) begin
        case (paddr[AddrW-1:2])
          REG_BASE_INTV: regs.base_intv = pwdata[IntvW-1:0];
          REG_MAX_INTV:  regs.max_intv  = pwdata[IntvW-1:0];
          REG_CONN_TO:   regs.conn_to   = pwdata[TimeW-1:0];
          REG_HB_TO:     regs.hb_to     = pwdata[TimeW-1:0];
          REG_MAX_ATT:   regs.max_att   = pwdata[CountW-1:0];
          default: ;
        endcase
      end
    end
    pending_results = predicted_status_q.size();
  end

endmodule

// ===== dv/link_reconnect_supervisor_top_tb.sv =====
module link_reconnect_supervisor_top_tb;
  import lrs_pkg::*;

  localparam int unsigned ClkPeriod      = 8;
  localparam int unsigned ResetCycles    = 9;
  localparam int unsigned SettleCycles   = 4;
  localparam int unsigned HoldOffCycles  = 150;
  localparam int unsigned NumPhases      = 8;
  localparam int unsigned ItemsPerPhase  = 138;
  localparam int unsigned WatchdogCycles = 400000;

  // Opcode that the supervisor ignores, and a register slot past the last one.
  localparam logic [OpW-1:0] OpUnused   = 3'd7;
  localparam logic [2:0]     RegBeyond  = 3'd5;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OpW-1:0]      in_opcode = '0;
  logic [TimeW-1:0]    in_now_ms = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [2:0]          out_link_state;
  logic [CodeW-1:0]    out_event_code;
  logic [CountW-1:0]   out_attempt_count;
  logic [IntvW-1:0]    out_current_interval;
  logic [TimeW-1:0]    out_connected_for;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AddrW-1:0]    paddr = '0;
  logic [DataW-1:0]    pwdata = '0;
  logic [DataW-1:0]    prdata;
  logic                pready;
  int unsigned         pending_results;
  int unsigned         mismatch_count;
  logic [TimeW-1:0]    clock_ms = '0;
  bit                  hold_off_go = 1'b0;

  always begin
    #(ClkPeriod / 2) clk = 1'b1;
    #(ClkPeriod / 2) clk = 1'b0;
  end

  link_reconnect_supervisor_top i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_opcode            (in_opcode),
    .in_now_ms            (in_now_ms),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_link_state       (out_link_state),
    .out_event_code       (out_event_code),
    .out_attempt_count    (out_attempt_count),
    .out_current_interval (out_current_interval),
    .out_connected_for    (out_connected_for),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  link_reconnect_supervisor_checker i_link_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_opcode            (in_opcode),
    .in_now_ms            (in_now_ms),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_link_state       (out_link_state),
    .out_event_code       (out_event_code),
    .out_attempt_count    (out_attempt_count),
    .out_current_interval (out_current_interval),
    .out_connected_for    (out_connected_for),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .pready               (pready),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .pending_results      (pending_results),
    .mismatch_count       (mismatch_count)
  );

  // Offer one request and hold it until the block takes it.
  task automatic send_request(input logic [OpW-1:0] op, input logic [TimeW-1:0] now);
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_now_ms <= now;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait until every predicted result has been delivered.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the select stays up for a following write.
  task automatic write_reg(input logic [2:0] idx, input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  // Write every register, plus one slot past the end that must be ignored.
  task automatic program_limits(input logic [31:0] base, input logic [31:0] ceiling,
                                input logic [31:0] conn_limit, input logic [31:0] hb_limit,
                                input logic [31:0] attempts);
    write_reg(REG_BASE_INTV, base);
    write_reg(REG_MAX_INTV, ceiling);
    write_reg(REG_CONN_TO, conn_limit);
    write_reg(REG_HB_TO, hb_limit);
    write_reg(REG_MAX_ATT, attempts);
    write_reg(RegBeyond, $urandom());
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Calm traffic is mostly ticks, so retry chains run long enough to fail.
  function automatic logic [OpW-1:0] pick_opcode(input bit calm);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm) begin
      if (roll < 76) return OP_TICK;
      if (roll < 88) return OP_HEARTBEAT;
      if (roll < 92) return OP_CONNECTING;
      if (roll < 95) return OP_CONNECTED;
      if (roll < 96) return OP_DISCONNECT;
      if (roll < 97) return OP_RECONNECT;
      if (roll < 98) return OP_BEGIN;
      return OpUnused;
    end
    if (roll < 50) return OP_TICK;
    if (roll < 58) return OP_CONNECTED;
    if (roll < 66) return OP_CONNECTING;
    if (roll < 72) return OP_DISCONNECT;
    if (roll < 78) return OP_RECONNECT;
    if (roll < 90) return OP_HEARTBEAT;
    if (roll < 96) return OP_BEGIN;
    return OpUnused;
  endfunction

  // Result side: random stall patterns drawn from four modes, and one
  // long hold-off on request so that the block backs up into its input.
  initial begin : result_sink
    int unsigned mode;
    int unsigned left;
    mode = 0;
    left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_off_go) begin
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
        hold_off_go = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(16, 96);
        end
        left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int unsigned  step_max;
    int unsigned  burst_left;
    int unsigned  gap;
    bit           calm;
    bit           gaps_on;
    logic [31:0]  base;

    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests under the reset register values.
    send_request(OP_TICK, 32'd0);
    send_request(OP_TICK, 32'd1000);          // elapsed equals the interval: stays
    send_request(OP_TICK, 32'd1001);          // disconnected times out into reconnecting
    send_request(OP_TICK, 32'd2001);          // first attempt, interval doubles
    send_request(OP_CONNECTING, 32'd2005);
    send_request(OP_CONNECTING, 32'd2006);    // same state again: no event
    send_request(OP_TICK, 32'd12001);         // connect timeout reached but not passed
    send_request(OP_TICK, 32'd12002);         // connecting times out
    send_request(OP_TICK, 32'd14002);         // second attempt
    send_request(OP_CONNECTED, 32'd14010);
    send_request(OP_CONNECTED, 32'd14011);
    send_request(OP_HEARTBEAT, 32'd20000);
    send_request(OP_TICK, 32'd80000);         // heartbeat limit reached, not passed
    send_request(OP_TICK, 32'd80001);         // link lost
    send_request(OP_DISCONNECT, 32'd80002);
    send_request(OP_RECONNECT, 32'd80003);
    send_request(OP_RECONNECT, 32'd80004);
    send_request(OP_BEGIN, 32'hFFFF_FFFF);
    send_request(OpUnused, 32'h5555_5555);
    send_request(OP_CONNECTED, 32'hFFFF_FFF0);
    send_request(OP_TICK, 32'h0000_0010);     // heartbeat age wraps around zero
    send_request(OP_HEARTBEAT, 32'hAAAA_AAAA);
    send_request(OP_TICK, 32'h0000_0000);     // huge wrapped age drops the link
    send_request(OP_RECONNECT, 32'h7FFF_FFFF);
    send_request(OP_DISCONNECT, 32'h8000_0000);

    // Random phases, each under its own register setting.
    for (int unsigned phase_idx = 0; phase_idx < NumPhases; phase_idx++) begin
      drain_results();
      case (phase_idx)
        0: begin
          program_limits(32'd1000, 32'd30000, 32'd10000, 32'd60000, 32'd10);
          step_max = 3000; calm = 1'b1; gaps_on = 1'b0;
        end
        1: begin
          // Smallest timeouts and an attempt budget of zero, with base and ceiling of one.
          program_limits(32'd1, 32'd1, 32'd0, 32'd0, 32'd0);
          step_max = 3; calm = 1'b0; gaps_on = 1'b1;
        end
        2: begin
          program_limits(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFF);
          step_max = 32'hFFFF_FFFF; calm = 1'b1; gaps_on = 1'b1;
        end
        3: begin
          // Zero base and ceiling give a zero interval.
          program_limits(32'd0, 32'd0, 32'd5, 32'd7, 32'd3);
          step_max = 8; calm = 1'b1; gaps_on = 1'b1;
        end
        4: begin
          // Base above the ceiling, with the unused top bit of the base set.
          program_limits(32'h8000_01F4, 32'd100, 32'd50, 32'd80, 32'd4);
          step_max = 200; calm = 1'b1; gaps_on = 1'b0;
        end
        default: begin
          base = $urandom_range(1, 64);
          base[31] = 1'($urandom_range(0, 1));
          program_limits(base, $urandom_range(1, 600), $urandom_range(0, 300),
                         $urandom_range(0, 600), $urandom_range(0, 8));
          step_max = $urandom_range(1, 250);
          calm = phase_idx[0];
          gaps_on = (phase_idx != 6);
        end
      endcase

      if (phase_idx == 1) hold_off_go = 1'b1;

      burst_left = 0;
      for (int unsigned k = 0; k < ItemsPerPhase; k++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap = gaps_on ? $urandom_range(0, 5) : 0;
          if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        if ($urandom_range(0, 19) == 0) clock_ms = $urandom();
        else clock_ms = clock_ms + $urandom_range(0, step_max);
        send_request(pick_opcode(calm), clock_ms);
        burst_left--;
      end
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Ends a run that hangs waiting for requests or results.
  initial begin : watchdog
    #(ClkPeriod * WatchdogCycles);
    $display("ERROR: timeout with %0d results outstanding", pending_results);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
